FILE: rtl/btt_pkg.sv
// btt_pkg: types and constants shared by the bookmark toggle table modules
// no dependencies
`default_nettype none

package btt_pkg;

  localparam int KEY_W   = 32;
  localparam int OFF_W   = 64;
  localparam int CTX_W   = 32;
  localparam int NTH_W   = 6;
  localparam int MCNT_W  = 7;

  typedef enum logic [1:0] {
    OP_TOGGLE = 2'd0,
    OP_TEST   = 2'd1,
    OP_COUNT  = 2'd2,
    OP_FETCH  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_RESULT
  } back_state_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [OFF_W-1:0] off;
    logic [CTX_W-1:0] ctx;
  } entry_t;

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [OFF_W-1:0] off;
    logic [CTX_W-1:0] ctx;
    logic [NTH_W-1:0] nth;
  } req_t;

  typedef struct packed {
    logic              status;
    logic              now_set;
    logic              found;
    logic [MCNT_W-1:0] match_count;
    logic [OFF_W-1:0]  found_offset;
    logic [CTX_W-1:0]  found_context;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/btt_if.sv
// btt_in_if / btt_out_if: valid-ready channels of the bookmark toggle table
// depends on btt_pkg for field widths
`default_nettype none

interface btt_in_if
  import btt_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [1:0]       op;
  logic [KEY_W-1:0] content_key;
  logic [OFF_W-1:0] entry_offset;
  logic [CTX_W-1:0] entry_context;
  logic [NTH_W-1:0] nth_index;

  modport source (output valid, op, content_key, entry_offset, entry_context, nth_index,
                  input ready);
  modport sink   (input valid, op, content_key, entry_offset, entry_context, nth_index,
                  output ready);
endinterface

interface btt_out_if
  import btt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              status;
  logic              now_set;
  logic              found;
  logic [MCNT_W-1:0] match_count;
  logic [OFF_W-1:0]  found_offset;
  logic [CTX_W-1:0]  found_context;

  modport source (output valid, status, now_set, found, match_count, found_offset,
                  found_context, input ready);
  modport sink   (input valid, status, now_set, found, match_count, found_offset,
                  found_context, output ready);
endinterface

`default_nettype wire

FILE: rtl/btt_front.sv
// btt_front: input sink, op decode and a two-entry request queue
// depends on btt_pkg and btt_in_if
`default_nettype none

module btt_front
  import btt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  btt_in_if.sink    in_ch,
  output req_t      req_o,
  output logic      req_vld_o,
  input  wire logic req_pop_i
);

  req_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push, pop;
  req_t       in_req;

  assign in_ch.ready = (fill_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = req_pop_i && (fill_r != 2'd0);
  assign req_vld_o   = (fill_r != 2'd0);
  assign req_o       = q_r[rd_ptr_r];

  always_comb begin
    in_req.op  = op_t'(in_ch.op);
    in_req.key = in_ch.content_key;
    in_req.off = in_ch.entry_offset;
    in_req.ctx = in_ch.entry_context;
    // only fetch uses the index; the context passes through for every op
    in_req.nth = (in_req.op == OP_FETCH) ? in_ch.nth_index : '0;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_req;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/btt_back.sv
// btt_back: entry memory, scan engine and result register
// depends on btt_pkg and btt_out_if
`default_nettype none

module btt_back
  import btt_pkg::*;
#(
  parameter int MAX_ENTRIES = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  req_t      req_i,
  input  wire logic req_vld_i,
  output logic      req_pop_o,
  btt_out_if.source out_ch
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  entry_t mem [MAX_ENTRIES];
  entry_t rd_data_r;

  back_state_t      state_r, state_nxt;
  req_t             req_r, req_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] issue_r, issue_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic [NTH_W:0]   seen_r, seen_nxt;
  res_t             res_r, res_nxt;
  logic             out_vld_r, out_vld_nxt;
  res_t             out_r, out_nxt;

  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic [CNT_W-1:0] cnt_m1;
  logic             key_hit, pair_hit, stop;

  assign cnt_m1   = cnt_r - 1'b1;
  assign key_hit  = (rd_data_r.key == req_r.key);
  assign pair_hit = key_hit && (rd_data_r.off == req_r.off);

  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    cnt_nxt     = cnt_r;
    issue_nxt   = issue_r;
    cmp_vld_nxt = cmp_vld_r;
    cmp_idx_nxt = cmp_idx_r;
    hit_idx_nxt = hit_idx_r;
    seen_nxt    = seen_r;
    res_nxt     = res_r;
    out_vld_nxt = out_vld_r && !out_ch.ready;
    out_nxt     = out_r;
    req_pop_o   = 1'b0;
    rd_addr     = issue_r[IDX_W-1:0];
    wr_en       = 1'b0;
    wr_addr     = cnt_r[IDX_W-1:0];
    wr_data     = '{key: req_r.key, off: req_r.off, ctx: req_r.ctx};
    stop        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (req_vld_i) begin
          req_pop_o   = 1'b1;
          req_nxt     = req_i;
          issue_nxt   = '0;
          cmp_vld_nxt = 1'b0;
          seen_nxt    = '0;
          res_nxt     = '0;
          state_nxt   = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // compare stage sees the entry read in the previous cycle
        if (cmp_vld_r) begin
          unique case (req_r.op)
            OP_TOGGLE: begin
              if (pair_hit) begin
                stop        = 1'b1;
                hit_idx_nxt = cmp_idx_r;
                state_nxt   = ST_MOVE_RD;
              end
            end
            OP_TEST: begin
              if (pair_hit) begin
                stop          = 1'b1;
                res_nxt.found = 1'b1;
                state_nxt     = ST_RESULT;
              end
            end
            OP_COUNT: begin
              if (key_hit && (res_r.match_count != '1)) begin
                res_nxt.match_count = res_r.match_count + 1'b1;
              end
            end
            OP_FETCH: begin
              if (key_hit) begin
                if (seen_r == {1'b0, req_r.nth}) begin
                  stop                  = 1'b1;
                  res_nxt.found         = 1'b1;
                  res_nxt.found_offset  = rd_data_r.off;
                  res_nxt.found_context = rd_data_r.ctx;
                  state_nxt             = ST_RESULT;
                end else if (!seen_r[NTH_W]) begin
                  seen_nxt = seen_r + 1'b1;
                end
              end
            end
            default: ;
          endcase
        end

        if (stop) begin
          cmp_vld_nxt = 1'b0;
        end else if (issue_r < cnt_r) begin
          issue_nxt   = issue_r + 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = issue_r[IDX_W-1:0];
        end else begin
          cmp_vld_nxt = 1'b0;
          if (!cmp_vld_r) begin
            // scan done with no early exit; a toggle now appends unless the table is full
            if (req_r.op == OP_TOGGLE) begin
              if (cnt_r == CNT_W'(MAX_ENTRIES)) begin
                res_nxt.status = 1'b1;
              end else begin
                wr_en           = 1'b1;
                cnt_nxt         = cnt_r + 1'b1;
                res_nxt.now_set = 1'b1;
              end
            end
            state_nxt = ST_RESULT;
          end
        end
      end

      ST_MOVE_RD: begin
        rd_addr   = cnt_m1[IDX_W-1:0];
        state_nxt = ST_MOVE_WR;
      end

      ST_MOVE_WR: begin
        // last entry fills the hole
        wr_en     = 1'b1;
        wr_addr   = hit_idx_r;
        wr_data   = rd_data_r;
        cnt_nxt   = cnt_m1;
        state_nxt = ST_RESULT;
      end

      ST_RESULT: begin
        if (!out_vld_r || out_ch.ready) begin
          out_vld_nxt = 1'b1;
          out_nxt     = res_r;
          state_nxt   = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      issue_r   <= '0;
      cmp_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      issue_r   <= issue_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    hit_idx_r <= hit_idx_nxt;
    seen_r    <= seen_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.status        = out_r.status;
  assign out_ch.now_set       = out_r.now_set;
  assign out_ch.found         = out_r.found;
  assign out_ch.match_count   = out_r.match_count;
  assign out_ch.found_offset  = out_r.found_offset;
  assign out_ch.found_context = out_r.found_context;

endmodule

`default_nettype wire

FILE: rtl/bookmark_toggle_table.sv
// bookmark_toggle_table: packed key/offset/context table with toggle, test,
// count and fetch; top level joining btt_front and btt_back (btt_pkg, btt_if)
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    op, content_key, entry_offset, entry_context, nth_index
//   out_ch   out  valid/ready    status, now_set, found, match_count,
//                                found_offset, found_context
//
// a toggle that removes an entry moves the last entry into the hole. the scan reads
// one table entry per cycle over a single read port; test and toggle stop early on a
// key/offset hit, fetch on its nth key hit, count reads every entry. a two-entry queue
// takes new items during a scan. reset empties the table at once (no clearing pass). a
// stalled result holds in the output register; the next result waits until it is taken.
`default_nettype none

module bookmark_toggle_table
  import btt_pkg::*;
#(
  parameter int MAX_ENTRIES = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  btt_in_if.sink    in_ch,
  btt_out_if.source out_ch
);

  req_t req;
  logic req_vld;
  logic req_pop;

  btt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .req_o     (req),
    .req_vld_o (req_vld),
    .req_pop_i (req_pop)
  );

  btt_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_i     (req),
    .req_vld_i (req_vld),
    .req_pop_o (req_pop),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

FILE: rtl/btt_checker.sv
// btt_checker: result consistency checks on the bookmark toggle table ports
// depends on btt_pkg; bound to bookmark_toggle_table below
`default_nettype none

module btt_checker
  import btt_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_status,
  input wire logic              out_now_set,
  input wire logic              out_found,
  input wire logic [MCNT_W-1:0] out_match_count,
  input wire logic [OFF_W-1:0]  out_found_offset,
  input wire logic [CTX_W-1:0]  out_found_context
);

  // a full table refuses the add and reports nothing else
  a_full_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> !out_now_set && !out_found && out_match_count == '0)
    else $error("capacity result carries other fields");

  // found comes only from test or fetch, never with a count
  a_found_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_match_count == '0 && !out_now_set)
    else $error("found together with count or set");

  a_count_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_match_count != '0 |-> !out_found && !out_now_set && !out_status)
    else $error("count result carries other fields");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_found_offset == '0 && out_found_context == '0)
    else $error("fetch data without a hit");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind bookmark_toggle_table btt_checker u_btt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_status        (out_ch.status),
  .out_now_set       (out_ch.now_set),
  .out_found         (out_ch.found),
  .out_match_count   (out_ch.match_count),
  .out_found_offset  (out_ch.found_offset),
  .out_found_context (out_ch.found_context)
);

`default_nettype wire
